// ===== sv/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// jsu_pkg
// Types, codes and character helpers for the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

    localparam int BYTE_W   = 8;
    localparam int CHAR_W   = 7;
    localparam int STATUS_W = 2;
    localparam int MODE_W   = 3;
    localparam int ACC_W    = 16;
    localparam int HEXCNT_W = 2;

    // decoder modes
    localparam logic [MODE_W-1:0] MODE_IDLE  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_BODY  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ESC   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_HEX   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DONE  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_ERROR = 3'd5;

    // reported status
    localparam logic [STATUS_W-1:0] ST_IDLE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BUSY  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ERROR = 2'd3;

    localparam logic [BYTE_W-1:0] QUOTE_CHAR  = 8'h22;
    localparam logic [BYTE_W-1:0] BSLASH_CHAR = 8'h5C;
    localparam logic [BYTE_W-1:0] SLASH_CHAR  = 8'h2F;
    localparam logic [BYTE_W-1:0] U_CHAR      = 8'h75;
    localparam logic [CHAR_W-1:0] SUBST_CHAR  = 7'h3F;
    localparam logic [ACC_W-1:0]  ASCII_MAX   = 16'h007F;
    localparam logic [HEXCNT_W-1:0] HEX_LAST  = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              start_string;
        logic              body_end;
    } in_item_t;

    typedef struct packed {
        logic              char_valid;
        logic [CHAR_W-1:0] decoded_char;
        logic [STATUS_W-1:0] status;
    } out_item_t;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [ACC_W-1:0]    hex_accum;
        logic [HEXCNT_W-1:0] hex_cnt;
    } state_t;

    // {ok, nibble} for one hex digit in either case
    function automatic logic [4:0] hex_digit(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] d;
        d = '0;
        if (b inside {[8'h30:8'h39]}) begin
            d = b - 8'h30;
            return {1'b1, d[3:0]};
        end
        else if (b inside {[8'h61:8'h66]}) begin
            d = b - 8'h57;
            return {1'b1, d[3:0]};
        end
        else if (b inside {[8'h41:8'h46]}) begin
            d = b - 8'h37;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

    // {ok, character} for the single-character escapes
    function automatic logic [CHAR_W:0] escape_char(input logic [BYTE_W-1:0] b);
        logic [CHAR_W:0] r;
        r = '0;
        case (b)
            QUOTE_CHAR:  r = {1'b1, QUOTE_CHAR[CHAR_W-1:0]};
            BSLASH_CHAR: r = {1'b1, BSLASH_CHAR[CHAR_W-1:0]};
            SLASH_CHAR:  r = {1'b1, SLASH_CHAR[CHAR_W-1:0]};
            8'h62:       r = {1'b1, 7'h08};
            8'h66:       r = {1'b1, 7'h0C};
            8'h6E:       r = {1'b1, 7'h0A};
            8'h72:       r = {1'b1, 7'h0D};
            8'h74:       r = {1'b1, 7'h09};
            default:     r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/jsu_if.sv =====
// ----------------------------------------------------------------------------
// jsu_in_if / jsu_out_if
// Valid/ready channels carrying raw bytes in and decoded characters out.
// ----------------------------------------------------------------------------
interface jsu_in_if;
    logic                          valid;
    logic                          ready;
    logic [jsu_pkg::BYTE_W-1:0]    in_byte;
    logic                          start_string;
    logic                          body_end;

    modport source (output valid, output in_byte, output start_string,
                    output body_end, input ready);
    modport sink   (input valid, input in_byte, input start_string,
                    input body_end, output ready);
endinterface

interface jsu_out_if;
    logic                          valid;
    logic                          ready;
    logic                          char_valid;
    logic [jsu_pkg::CHAR_W-1:0]    decoded_char;
    logic [jsu_pkg::STATUS_W-1:0]  status;

    modport source (output valid, output char_valid, output decoded_char,
                    output status, input ready);
    modport sink   (input valid, input char_valid, input decoded_char,
                    input status, output ready);
endinterface

// ===== sv/jsu_decode.sv =====
// ----------------------------------------------------------------------------
// jsu_decode
// Next-state and result logic for one byte of a quoted string.
// ----------------------------------------------------------------------------
module jsu_decode (
    input  jsu_pkg::state_t    cur,
    input  jsu_pkg::in_item_t  item,
    output jsu_pkg::state_t    nxt,
    output jsu_pkg::out_item_t res
);
    import jsu_pkg::*;

    logic [BYTE_W-1:0] b;
    logic              last;
    logic [4:0]        hx;
    logic [CHAR_W:0]   esc;
    logic [ACC_W-1:0]  acc_new;

    assign b       = item.in_byte;
    assign last    = item.body_end;
    assign hx      = hex_digit(b);
    assign esc     = escape_char(b);
    assign acc_new = {cur.hex_accum[ACC_W-5:0], hx[3:0]};

    always_comb
    begin
        nxt = cur;
        res = '0;
        res.status = ST_IDLE;
        if (item.start_string)
        begin
            nxt.hex_accum = '0;
            nxt.hex_cnt   = '0;
            if (b != QUOTE_CHAR || last)
            begin
                nxt.mode   = MODE_ERROR;
                res.status = ST_ERROR;
            end
            else
            begin
                nxt.mode   = MODE_BODY;
                res.status = ST_BUSY;
            end
        end
        else
        begin
            case (cur.mode)
                MODE_BODY:
                begin
                    if (b == QUOTE_CHAR)
                    begin
                        nxt.mode   = MODE_DONE;
                        res.status = ST_DONE;
                    end
                    else if (last)
                    begin
                        nxt.mode   = MODE_ERROR;
                        res.status = ST_ERROR;
                    end
                    else if (b == BSLASH_CHAR)
                    begin
                        nxt.mode   = MODE_ESC;
                        res.status = ST_BUSY;
                    end
                    else
                    begin
                        // non-ascii bytes do not fit in seven bits
                        res.char_valid   = 1'b1;
                        res.decoded_char = b[BYTE_W-1] ? SUBST_CHAR : b[CHAR_W-1:0];
                        res.status       = ST_BUSY;
                    end
                end
                MODE_ESC:
                begin
                    if (b == U_CHAR)
                    begin
                        if (last)
                        begin
                            nxt.mode   = MODE_ERROR;
                            res.status = ST_ERROR;
                        end
                        else
                        begin
                            nxt.hex_accum = '0;
                            nxt.hex_cnt   = '0;
                            nxt.mode      = MODE_HEX;
                            res.status    = ST_BUSY;
                        end
                    end
                    else if (!esc[CHAR_W] || last)
                    begin
                        nxt.mode   = MODE_ERROR;
                        res.status = ST_ERROR;
                    end
                    else
                    begin
                        nxt.mode         = MODE_BODY;
                        res.char_valid   = 1'b1;
                        res.decoded_char = esc[CHAR_W-1:0];
                        res.status       = ST_BUSY;
                    end
                end
                MODE_HEX:
                begin
                    if (!hx[4] || last)
                    begin
                        nxt.mode   = MODE_ERROR;
                        res.status = ST_ERROR;
                    end
                    else
                    begin
                        nxt.hex_accum = acc_new;
                        res.status    = ST_BUSY;
                        if (cur.hex_cnt == HEX_LAST)
                        begin
                            nxt.hex_cnt      = '0;
                            nxt.mode         = MODE_BODY;
                            res.char_valid   = 1'b1;
                            res.decoded_char = (acc_new <= ASCII_MAX) ?
                                               acc_new[CHAR_W-1:0] : SUBST_CHAR;
                        end
                        else
                        begin
                            nxt.hex_cnt = HEXCNT_W'(cur.hex_cnt + 2'd1);
                        end
                    end
                end
                MODE_DONE:  res.status = ST_DONE;
                MODE_ERROR: res.status = ST_ERROR;
                default:    res.status = ST_IDLE;
            endcase
        end
    end

endmodule

// ===== sv/json_string_unescape_top.sv =====
// ----------------------------------------------------------------------------
// json_string_unescape_top
// Byte-wide decoder for one quoted JSON string value.
// ----------------------------------------------------------------------------
// in_ch carries one raw byte per transfer, with start_string marking the
// opening quote and body_end marking the last byte of the body. out_ch
// carries exactly one result per input byte: char_valid, decoded_char and a
// status of idle, in progress, complete or error.
// A byte is captured in the input register on its transfer and decoded into
// the result register once that register can advance, and its result is
// offered on out_ch from there.
// One byte per cycle is taken while out_ch does not stall; the decode state
// (mode, hex accumulator, digit count) is updated as each byte's result is
// committed, which is what sets that rate.
// When the receiver stalls, the result register holds and the input register
// fills; in_ch.ready drops only once both are occupied.
// Reset empties both registers and returns the decoder to idle, where it
// reports status idle until a start byte arrives.
// ----------------------------------------------------------------------------
module json_string_unescape_top (
    input  logic      clk,
    input  logic      rst_n,
    jsu_in_if.sink    in_ch,
    jsu_out_if.source out_ch
);
    import jsu_pkg::*;

    logic      s1_valid_reg;
    logic      s1_valid_next;
    in_item_t  s1_item_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_item_reg;
    state_t    state_reg;
    state_t    state_next;
    out_item_t res;
    logic      out_adv;
    logic      s1_adv;
    logic      in_fire;

    assign out_adv = !out_valid_reg || out_ch.ready;
    assign s1_adv  = s1_valid_reg && out_adv;
    assign in_ch.ready = !s1_valid_reg || out_adv;
    assign in_fire = in_ch.valid && in_ch.ready;

    assign s1_valid_next  = in_ch.ready ? in_ch.valid : s1_valid_reg;
    assign out_valid_next = out_adv ? s1_valid_reg : out_valid_reg;

    jsu_decode u_decode (
        .cur  (state_reg),
        .item (s1_item_reg),
        .nxt  (state_next),
        .res  (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{mode: MODE_IDLE, hex_accum: '0, hex_cnt: '0};
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            // state moves only when a byte's result is committed
            if (s1_adv)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg <= '{in_byte: in_ch.in_byte, start_string: in_ch.start_string,
                             body_end: in_ch.body_end};
        end
        if (s1_adv)
        begin
            out_item_reg <= res;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.char_valid   = out_item_reg.char_valid;
    assign out_ch.decoded_char = out_item_reg.decoded_char;
    assign out_ch.status       = out_item_reg.status;

    // a character is only ever emitted mid-string
    a_char_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.char_valid |-> out_item_reg.status == ST_BUSY)
        else $error("character emitted outside a string");

    a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_item_reg.char_valid |-> out_item_reg.decoded_char == '0)
        else $error("decoded_char not cleared without a character");

    // digit count only runs inside a unicode escape, or is left over by a bad one
    a_hex_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.hex_cnt != '0 |-> state_reg.mode == MODE_HEX
                                   || state_reg.mode == MODE_ERROR)
        else $error("hex digit count set outside a unicode escape");

    a_in_capture: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> s1_valid_reg)
        else $error("accepted byte lost from the input register");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_adv |=> $stable(state_reg))
        else $error("decode state changed without a committed byte");

endmodule
